>>> hw/rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window median unit
// Window size, field widths, the cell link and control structs.
// ----------------------------------------------------------------------------
package swm_pkg;

   // largest window the cell chain holds
   localparam int MAX_WINDOW = 64;

   // field widths
   localparam int SAMPLE_W = 32;
   localparam int MEDIAN_W = SAMPLE_W + 1;
   localparam int CSR_W    = 7;

   // window length / fill count width, slot address width
   localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
   localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   // window length after reset
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);

   // data handed between neighboring cells
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;  // window entry
      logic                       le_new; // entry is <= incoming sample
   } swm_link_type;

   // control broadcast to every cell
   typedef struct packed {
      logic                       upd;    // apply the update this cycle
      logic                       rm;     // evict one copy of old_val
      logic signed [SAMPLE_W-1:0] old_val;
      logic signed [SAMPLE_W-1:0] new_val;
      logic [LEN_W-1:0]           kept;   // entries left after eviction
   } swm_ctrl_type;

endpackage

>>> hw/rtl/swm_req_if.sv
// ----------------------------------------------------------------------------
// swm_req_if: request channel of the sliding window median unit
// Valid/ready handshake carrying one sample and the start flag.
// ----------------------------------------------------------------------------
interface swm_req_if import swm_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       start_of_sequence;

   modport source (output valid, sample, start_of_sequence, input ready);
   modport sink   (input valid, sample, start_of_sequence, output ready);

endinterface

>>> hw/rtl/swm_rsp_if.sv
// ----------------------------------------------------------------------------
// swm_rsp_if: response channel of the sliding window median unit
// Valid/ready handshake carrying the doubled median.
// ----------------------------------------------------------------------------
interface swm_rsp_if import swm_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic signed [MEDIAN_W-1:0] median_doubled;

   modport source (output valid, median_doubled, input ready);
   modport sink   (input valid, median_doubled, output ready);

endinterface

>>> hw/rtl/sliding_window_median_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_median_unit: running median over a sliding sample window
// Arrival order lives in a RAM, sorted order in a chain of cells.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  req_if    in    valid / ready    sample (s32), start_of_sequence
//  rsp_if    out   valid / ready    median_doubled (s33)
//  csr_*     in    csr_we           csr_wdata = window_len (u7)
//
//  Each request steps through accept plus history RAM read, cell chain
//  update and median pick into the response register (the pick is skipped
//  while the window is still filling). The registered read of the oldest slot keeps the update apart from the accept.
//  Reset (synchronous) empties the window and sets window_len to 3.
//  A waiting response does not block the next request; only the median
//  pick step waits for the response register to free up.
// ----------------------------------------------------------------------------
module sliding_window_median_unit import swm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_W-1:0]     csr_wdata,
   swm_req_if.sink              req_if,
   swm_rsp_if.source            rsp_if
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_UPDATE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WINDOW);

   state_type                  state_ff, state_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic [LEN_W-1:0]           fill_ff, fill_in;
   logic [SLOT_W-1:0]          oldest_ff, oldest_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [MEDIAN_W-1:0] rsp_data_ff, rsp_data_in;

   logic                       req_fire;
   logic                       full;
   logic                       emit;
   logic [LEN_W-1:0]           csr_len;
   logic [LEN_W-1:0]           oldest_next;
   logic [SLOT_W-1:0]          raddr;
   logic [SLOT_W-1:0]          waddr;
   logic signed [SAMPLE_W-1:0] old_val;
   swm_ctrl_type               ctrl;

   swm_link_type               rlink [MAX_WINDOW];
   swm_link_type               llink [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] vals  [MAX_WINDOW];

   logic [LEN_W-1:0]           idx_hi;
   logic [LEN_W-1:0]           idx_lo;
   logic signed [SAMPLE_W-1:0] med_hi;
   logic signed [SAMPLE_W-1:0] med_lo;

   // handshake
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;

   // window status during the update cycle
   assign full        = (fill_ff == len_ff);
   assign emit        = full || ((fill_ff + LEN_W'(1)) == len_ff);
   assign oldest_next = {{(LEN_W-SLOT_W){1'b0}}, oldest_ff} + LEN_W'(1);

   // window_len write value, kept in 1..MAX_WINDOW
   always_comb begin
      csr_len = LEN_W'(csr_wdata);
      if (csr_wdata == '0) begin
         csr_len = LEN_W'(1);
      end else if (LEN_W'(csr_wdata) > LEN_MAX || (CSR_W > LEN_W &&
                   (csr_wdata >> LEN_W) != '0)) begin
         csr_len = LEN_MAX;
      end
   end

   // history RAM: read the oldest slot on accept, write in the update cycle
   assign raddr = req_if.start_of_sequence ? '0 : oldest_ff;
   assign waddr = full ? oldest_ff : fill_ff[SLOT_W-1:0];

   swm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW)
   ) u_history (
      .clock (clock),
      .we    (state_ff == ST_UPDATE),
      .waddr (waddr),
      .wdata (sample_ff),
      .raddr (raddr),
      .rdata (old_val)
   );

   // broadcast to the cell chain
   assign ctrl = '{
      upd:     (state_ff == ST_UPDATE),
      rm:      full,
      old_val: old_val,
      new_val: sample_ff,
      kept:    full ? (len_ff - LEN_W'(1)) : fill_ff
   };

   // sorted window: chain of cells
   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      swm_link_type left_in;
      swm_link_type right_in;

      if (i == 0) begin : g_first
         assign left_in = '{value: '0, le_new: 1'b1};
      end else begin : g_mid_l
         assign left_in = rlink[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_last
         assign right_in = '{value: '0, le_new: 1'b0};
      end else begin : g_mid_r
         assign right_in = llink[i+1];
      end

      swm_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .idx        (LEN_W'(i)),
         .from_left  (left_in),
         .from_right (right_in),
         .to_left    (llink[i]),
         .to_right   (rlink[i]),
         .value      (vals[i])
      );
   end

   // median taps
   assign idx_hi = len_ff >> 1;
   assign idx_lo = len_ff[0] ? idx_hi : (idx_hi - LEN_W'(1));
   assign med_hi = vals[idx_hi[SLOT_W-1:0]];
   assign med_lo = vals[idx_lo[SLOT_W-1:0]];

   // sequencer, counters and response register
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      fill_in      = fill_ff;
      oldest_in    = oldest_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sample_in = req_if.sample;
               if (req_if.start_of_sequence) begin
                  fill_in   = '0;
                  oldest_in = '0;
               end
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (full) begin
               oldest_in = (oldest_next < len_ff) ? oldest_next[SLOT_W-1:0] : '0;
            end else begin
               fill_in = fill_ff + LEN_W'(1);
            end
            state_in = emit ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = MEDIAN_W'(med_hi) + MEDIAN_W'(med_lo);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a new length starts a new sequence
      if (csr_we) begin
         len_in    = csr_len;
         fill_in   = '0;
         oldest_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_RESET;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.median_doubled = rsp_data_ff;

   // checks
   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_ff)
      else $error("fill count above window length");

   a_oldest_in_range: assert property (@(posedge clock) disable iff (reset)
      {{(LEN_W-SLOT_W){1'b0}}, oldest_ff} < len_ff)
      else $error("oldest slot outside window");

   a_oldest_only_full: assert property (@(posedge clock) disable iff (reset)
      oldest_ff != '0 |-> fill_ff == len_ff)
      else $error("ring pointer moved before window filled");

   a_update_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |=> state_ff != ST_UPDATE)
      else $error("cell update repeated");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && rsp_valid_ff && !rsp_if.ready |=>
         rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending response overwritten");

endmodule

>>> hw/rtl/swm_ram.sv
// ----------------------------------------------------------------------------
// swm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one entry of the sorted window
// Evicts and inserts in a single update using only its two neighbors.
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; (
   input  logic                       clock,
   input  swm_ctrl_type               ctrl,
   input  logic [LEN_W-1:0]           idx,
   input  swm_link_type               from_left,
   input  swm_link_type               from_right,
   output swm_link_type               to_left,
   output swm_link_type               to_right,
   output logic signed [SAMPLE_W-1:0] value
);

   logic signed [SAMPLE_W-1:0] val_ff;
   logic signed [SAMPLE_W-1:0] val_in;
   logic                       at_or_past_old;
   logic                       le_own;
   logic signed [SAMPLE_W-1:0] kept_val;
   logic                       kept_le;

   // entries at or after the first copy of the evicted value shift left
   assign at_or_past_old = ctrl.rm && (val_ff >= ctrl.old_val);
   assign le_own         = (val_ff <= ctrl.new_val);

   // window after eviction, seen at this position
   assign kept_val = at_or_past_old ? from_right.value : val_ff;
   assign kept_le  = (idx < ctrl.kept) && (at_or_past_old ? from_right.le_new : le_own);

   assign to_left  = '{value: val_ff, le_new: le_own};
   assign to_right = '{value: kept_val, le_new: kept_le};

   // insertion: keep, take the new sample, or take the left entry
   always_comb begin
      val_in = val_ff;
      if (ctrl.upd) begin
         if (kept_le) begin
            val_in = kept_val;
         end else if (from_left.le_new) begin
            val_in = ctrl.new_val;
         end else begin
            val_in = from_left.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign value = val_ff;

endmodule

>>> test/sliding_window_median_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_checker: response checker for the median unit
// Watches the csr port and both channels at the rising clock edge, keeps
// its own copy of the window (arrival ring plus sorted list) and queues the
// doubled median expected for every request that completes a full window.
// Each response is compared against the oldest queued median.
// ----------------------------------------------------------------------------
module sliding_window_median_checker import swm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_W-1:0]           csr_wdata,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_start_of_sequence,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [MEDIAN_W-1:0] rsp_median_doubled,
   output int                         mismatch_count,
   output int                         medians_pending
);

   // predicted window state
   logic [LEN_W-1:0]           window_len;
   logic signed [SAMPLE_W-1:0] arrival_ring [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] sorted_vals [MAX_WINDOW];
   int                         fill_count;
   int                         oldest_slot;

   // doubled medians still owed by the block, oldest first
   logic signed [MEDIAN_W-1:0] expected_medians [$];

   initial begin
      mismatch_count  = 0;
      medians_pending = 0;
   end

   // insert into the first count sorted entries, keeping ascending order
   function automatic void insert_sorted(input int count, input logic signed [SAMPLE_W-1:0] v);
      int i;
      i = count;
      while (i > 0 && sorted_vals[i-1] > v) begin
         sorted_vals[i] = sorted_vals[i-1];
         i--;
      end
      sorted_vals[i] = v;
   endfunction

   // drop one copy of v (the last entry if v is not present)
   function automatic void remove_sorted(input int count, input logic signed [SAMPLE_W-1:0] v);
      int pos;
      int i;
      pos = count - 1;
      i   = 0;
      while (i < count && sorted_vals[i] != v)
         i++;
      if (i < count)
         pos = i;
      for (i = pos; i + 1 < count; i++)
         sorted_vals[i] = sorted_vals[i+1];
   endfunction

   // apply one request to the window; report the median once it is full
   function automatic void advance_window(input logic signed [SAMPLE_W-1:0] s,
                                          input logic restart,
                                          output logic produced,
                                          output logic signed [MEDIAN_W-1:0] med);
      int                         len;
      logic signed [SAMPLE_W-1:0] evicted;
      logic signed [SAMPLE_W-1:0] lo;
      logic signed [SAMPLE_W-1:0] hi;
      len = int'(window_len);
      if (restart) begin
         fill_count  = 0;
         oldest_slot = 0;
      end
      if (fill_count < len) begin
         arrival_ring[fill_count] = s;
         insert_sorted(fill_count, s);
         fill_count++;
      end else begin
         evicted = arrival_ring[oldest_slot];
         remove_sorted(len, evicted);
         insert_sorted(len - 1, s);
         arrival_ring[oldest_slot] = s;
         oldest_slot = (oldest_slot + 1 < len) ? oldest_slot + 1 : 0;
      end
      produced = (fill_count >= len);
      med      = '0;
      if (len % 2 == 1) begin
         med = {sorted_vals[len/2], 1'b0};
      end else begin
         lo  = sorted_vals[len/2 - 1];
         hi  = sorted_vals[len/2];
         med = {lo[SAMPLE_W-1], lo} + {hi[SAMPLE_W-1], hi};
      end
   endfunction

   // watch the ports at every rising edge
   always @(posedge clock) begin
      logic                       produced;
      logic signed [MEDIAN_W-1:0] med;
      logic signed [MEDIAN_W-1:0] owed;
      if (reset) begin
         window_len  = LEN_RESET;
         fill_count  = 0;
         oldest_slot = 0;
         expected_medians.delete();
      end else begin
         // responses first: a request taken this edge cannot answer yet
         if (rsp_valid && rsp_ready) begin
            if (expected_medians.size() == 0) begin
               $display("%0t: unexpected response: expected none, got %0d",
                        $time, rsp_median_doubled);
               mismatch_count++;
            end else begin
               owed = expected_medians.pop_front();
               if (rsp_median_doubled !== owed) begin
                  $display("%0t: median mismatch: expected %0d, got %0d",
                           $time, owed, rsp_median_doubled);
                  mismatch_count++;
               end
            end
         end
         // window length write, clamped to 1..MAX_WINDOW, clears the window
         if (csr_we) begin
            if (csr_wdata == '0)
               window_len = LEN_W'(1);
            else if (int'(csr_wdata) > MAX_WINDOW)
               window_len = LEN_W'(MAX_WINDOW);
            else
               window_len = LEN_W'(csr_wdata);
            fill_count  = 0;
            oldest_slot = 0;
         end
         if (req_valid && req_ready) begin
            advance_window(req_sample, req_start_of_sequence, produced, med);
            // append to the tail of the owed list
            if (produced)
               expected_medians = {expected_medians, med};
         end
      end
      medians_pending = expected_medians.size();
   end

endmodule

>>> test/sliding_window_median_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_unit_tb: testbench for the sliding window median unit
// Directed requests hit sample extremes, duplicate eviction, restarts and
// odd/even/unit windows; random phases then sweep window lengths (including
// zero and saturating writes) under varied sender idling and receiver stalls,
// with one long receiver hold-off. Checking lives in the checker module.
// ----------------------------------------------------------------------------
module sliding_window_median_unit_tb;
   import swm_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fff_ffff;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CSR_W-1:0] csr_wdata;

   int   send_idle_pct;
   int   rsp_stall_pct;
   logic hold_active;
   int   mismatch_count;
   int   medians_pending;
   int   cycle_count = 0;
   event hold_go;

   swm_req_if req_ch ();
   swm_rsp_if rsp_ch ();

   sliding_window_median_unit dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch)
   );

   sliding_window_median_checker checker_i (
      .clock                 (clock),
      .reset                 (reset),
      .csr_we                (csr_we),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_ch.valid),
      .req_ready             (req_ch.ready),
      .req_sample            (req_ch.sample),
      .req_start_of_sequence (req_ch.start_of_sequence),
      .rsp_valid             (rsp_ch.valid),
      .rsp_ready             (rsp_ch.ready),
      .rsp_median_doubled    (rsp_ch.median_doubled),
      .mismatch_count        (mismatch_count),
      .medians_pending       (medians_pending)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("sliding_window_median_unit_tb: errors");
         $finish;
      end
   end

   // long receiver hold-off, counted here
   initial begin
      hold_active = 1'b0;
      forever begin
         @(hold_go);
         hold_active = 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_active = 1'b0;
      end
   end

   // receiver: random stalls on the response channel
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= !hold_active && ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // offer one request, return at the falling edge after it is taken
   task automatic send_request(input logic signed [SAMPLE_W-1:0] value, input logic restart);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.sample            <= value;
      req_ch.start_of_sequence <= restart;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // let every owed median arrive, then cover requests that give none
   task automatic wait_idle();
      req_ch.valid  <= 1'b0;
      rsp_stall_pct = 0;
      while (medians_pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_window_len(input int len);
      csr_wdata <= CSR_W'(len);
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // mostly wide values, with extremes and a narrow band for repeats
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return SAMPLE_MIN;
         1:       return SAMPLE_MAX;
         2, 3:    return SAMPLE_W'($urandom_range(0, 8)) - 32'sd4;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_phase(input int len, input int idle_pct, input int stall_pct,
                            input int count, input int restart_pct, input bit hold);
      int n;
      wait_idle();
      write_window_len(len);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (hold)
         -> hold_go;
      for (n = 0; n < count; n++)
         send_request(pick_sample(), $urandom_range(0, 99) < restart_pct);
   endtask

   // stimulus
   initial begin
      reset                    = 1'b1;
      csr_we                   = 1'b0;
      csr_wdata                = '0;
      req_ch.valid             = 1'b0;
      req_ch.sample            = '0;
      req_ch.start_of_sequence = 1'b0;
      send_idle_pct            = 0;
      rsp_stall_pct            = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // window of 3 out of reset: extremes, duplicates, restarts
      send_request(SAMPLE_MIN, 1'b1);
      send_request(SAMPLE_MAX, 1'b0);
      send_request(32'sd0, 1'b0);
      send_request(SAMPLE_MIN, 1'b0);
      send_request(SAMPLE_MIN, 1'b0);
      send_request(SAMPLE_MIN, 1'b0);
      send_request(SAMPLE_MAX, 1'b0);
      send_request(SAMPLE_MAX, 1'b0);
      send_request(SAMPLE_MAX, 1'b0);
      send_request(-32'sd1, 1'b1);
      send_request(32'sd1, 1'b0);
      send_request(-32'sd1, 1'b0);
      send_request(-32'sd1, 1'b0);

      // even window: median is the sum of the middle pair
      wait_idle();
      write_window_len(2);
      send_request(SAMPLE_MAX, 1'b1);
      send_request(SAMPLE_MAX, 1'b0);
      send_request(SAMPLE_MIN, 1'b0);
      send_request(SAMPLE_MIN, 1'b0);
      send_request(-32'sd1, 1'b0);
      send_request(32'sd0, 1'b0);

      // single-sample window
      wait_idle();
      write_window_len(1);
      send_request(32'sd7, 1'b0);
      send_request(-32'sd3, 1'b1);

      // random phases: length, sender idle %, receiver stall %, count
      run_phase(5, 0, 0, 70, 4, 1'b0);
      run_phase(0, 60, 0, 70, 4, 1'b0);
      run_phase(4, 0, 60, 70, 4, 1'b0);
      run_phase(127, 35, 35, 100, 0, 1'b0);
      run_phase(2, 0, 0, 70, 4, 1'b1);
      run_phase(7, 60, 0, 70, 4, 1'b0);
      run_phase(64, 0, 60, 100, 0, 1'b0);
      run_phase($urandom_range(1, 12), 35, 35, 70, 4, 1'b0);
      run_phase(3, 0, 0, 70, 4, 1'b0);
      run_phase(6, 35, 35, 70, 4, 1'b0);

      wait_idle();
      if (mismatch_count == 0)
         $display("sliding_window_median_unit_tb: clean");
      else
         $display("sliding_window_median_unit_tb: errors");
      $finish;
   end

endmodule
